// File: src/lrr_pkg.sv
package lrr_pkg;

  localparam int SampleW = 32;
  localparam int LenW    = 11;
  localparam int LimitW  = 31;
  localparam int PosW    = 16;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last_sample;
  } item_t;

  typedef struct packed {
    logic [LenW-1:0] longest_length;
    logic [LenW-1:0] window_length;
    logic            capped;
    logic            final_result;
  } result_t;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_CAP_RD  = 9'b000000010,
    ST_CAP     = 9'b000000100,
    ST_TAIL_RD = 9'b000001000,
    ST_TAIL    = 9'b000010000,
    ST_PUSH    = 9'b000100000,
    ST_SHR_RD  = 9'b001000000,
    ST_SHR     = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_t;

endpackage

// File: src/lrr_if.sv
interface lrr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lrr_pkg::SampleW-1:0]     sample;
  logic                                   last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface lrr_out_if;
  logic                       valid;
  logic                       ready;
  logic [lrr_pkg::LenW-1:0]   longest_length;
  logic [lrr_pkg::LenW-1:0]   window_length;
  logic                       capped;
  logic                       final_result;
  modport source (output valid, output longest_length, output window_length,
                  output capped, output final_result, input ready);
  modport sink (input valid, input longest_length, input window_length,
                input capped, input final_result, output ready);
endinterface

// File: src/longest_run_within_range_top.sv
// longest run within range: per sample, the longest window ending there whose
// max minus min stays at or below cfg_wdata (range limit), tracked by two
// monotonic deques held in block memories of depth WINDOW_MAX.
// in_ch: valid/ready stream of sample (signed 32) and last_sample.
// out_ch: one result per sample: longest_length, window_length, capped,
// final_result; a result register holds it until out_ch.ready.
// cfg_we/cfg_wdata write the range limit; write only while idle.
// a two-entry queue decouples intake from the deque sequencer.
// per sample the sequencer takes the item, moves the start once when the
// WINDOW_MAX cap demands it, pops the tails of both deques in parallel until
// neither pops, writes the new tails, advances the start while the span is
// over the limit, and loads the result; each cap, pop and advance step is a
// registered memory read then an update.
// reset (synchronous, rst_n low) empties the deques, positions and best
// length and sets the range limit to 0; the deque memories need no clearing.
// if out_ch stalls the sequencer waits with its result, and intake stops once
// the queue is full.
module longest_run_within_range_top #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lrr_pkg::LimitW-1:0]   cfg_wdata,
  lrr_in_if.sink                       in_ch,
  lrr_out_if.source                    out_ch
);

  logic [lrr_pkg::LimitW-1:0] limit_r;
  logic           item_valid, item_ready;
  lrr_pkg::item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= '0;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  lrr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  lrr_back #(.W(WINDOW_MAX)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .range_limit (limit_r),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .out_ch      (out_ch)
  );

endmodule

// File: src/lrr_front.sv
module lrr_front (
  input  logic            clk,
  input  logic            rst_n,
  lrr_in_if.sink          in_ch,
  output logic            item_valid,
  input  logic            item_ready,
  output lrr_pkg::item_t  item
);

  lrr_pkg::item_t q_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (cnt_r != 2'd0);
  assign pop         = item_valid && item_ready;
  assign item        = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_r].sample      <= in_ch.sample;
      q_r[wr_r].last_sample <= in_ch.last_sample;
    end
  end

endmodule

// File: src/lrr_back.sv
module lrr_back #(
  parameter int W = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lrr_pkg::LimitW-1:0]    range_limit,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lrr_pkg::item_t                item,
  lrr_out_if.source                     out_ch
);

  localparam int AW = (W > 1) ? $clog2(W) : 1;
  localparam int CW = $clog2(W + 1);
  localparam int EW = lrr_pkg::SampleW + lrr_pkg::PosW;
  localparam logic [lrr_pkg::PosW-1:0] WPOS = lrr_pkg::PosW'(W);
  localparam logic [CW:0] WRING = (CW+1)'(W);

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= WRING) s = s - WRING;
    return s[AW-1:0];
  endfunction

  lrr_pkg::state_t state_r, state_nxt;

  logic [EW-1:0] maxmem [W];
  logic [EW-1:0] minmem [W];
  logic [EW-1:0] maxrd_r, minrd_r;
  logic [AW-1:0] maxra, minra, maxwa, minwa;
  logic          mem_we;

  logic signed [lrr_pkg::SampleW-1:0] x_r, x_nxt;
  logic last_r, last_nxt, capped_r, capped_nxt;
  logic [lrr_pkg::PosW-1:0] pos_r, pos_nxt, ws_r, ws_nxt;
  logic [AW-1:0] maxh_r, maxh_nxt, minh_r, minh_nxt;
  logic [CW-1:0] maxc_r, maxc_nxt, minc_r, minc_nxt;
  logic [lrr_pkg::LenW-1:0] best_r, best_nxt;
  lrr_pkg::result_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic signed [lrr_pkg::SampleW-1:0] maxv, minv;
  logic [lrr_pkg::PosW-1:0] maxp, minp;
  logic signed [lrr_pkg::SampleW:0] diff;
  logic max_pop, min_pop;
  logic [lrr_pkg::PosW:0] len17;
  logic [lrr_pkg::LenW-1:0] len11;

  assign maxv = $signed(maxrd_r[EW-1 -: lrr_pkg::SampleW]);
  assign maxp = maxrd_r[lrr_pkg::PosW-1:0];
  assign minv = $signed(minrd_r[EW-1 -: lrr_pkg::SampleW]);
  assign minp = minrd_r[lrr_pkg::PosW-1:0];
  // exact 33-bit span of the window
  assign diff = {maxv[lrr_pkg::SampleW-1], maxv} - {minv[lrr_pkg::SampleW-1], minv};
  assign max_pop = (maxc_r != '0) && (maxv < x_r);
  assign min_pop = (minc_r != '0) && (minv > x_r);
  assign len17 = {1'b0, pos_r - ws_r} + 17'd1;
  assign len11 = (len17 > 17'd2047) ? 11'd2047 : len17[lrr_pkg::LenW-1:0];

  assign item_ready = (state_r == lrr_pkg::ST_IDLE);
  assign mem_we     = (state_r == lrr_pkg::ST_PUSH);
  assign maxwa      = ring(maxh_r, maxc_r);
  assign minwa      = ring(minh_r, minc_r);

  always_comb begin
    maxra = maxh_r;
    minra = minh_r;
    if (state_r == lrr_pkg::ST_TAIL_RD) begin
      maxra = ring(maxh_r, maxc_r - CW'(1));
      minra = ring(minh_r, minc_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      maxmem[maxwa] <= {x_r, pos_r};
      minmem[minwa] <= {x_r, pos_r};
    end
    maxrd_r <= maxmem[maxra];
    minrd_r <= minmem[minra];
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    capped_nxt    = capped_r;
    pos_nxt       = pos_r;
    ws_nxt        = ws_r;
    maxh_nxt      = maxh_r;
    minh_nxt      = minh_r;
    maxc_nxt      = maxc_r;
    minc_nxt      = minc_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      lrr_pkg::ST_IDLE: begin
        if (item_valid) begin
          x_nxt    = item.sample;
          last_nxt = item.last_sample;
          if ((pos_r - ws_r) >= WPOS) begin
            capped_nxt = 1'b1;
            state_nxt  = lrr_pkg::ST_CAP_RD;
          end else begin
            capped_nxt = 1'b0;
            state_nxt  = lrr_pkg::ST_TAIL_RD;
          end
        end
      end
      lrr_pkg::ST_CAP_RD: state_nxt = lrr_pkg::ST_CAP;
      lrr_pkg::ST_CAP: begin
        if (maxc_r != '0 && maxp == ws_r) begin
          maxh_nxt = ring(maxh_r, CW'(1));
          maxc_nxt = maxc_r - CW'(1);
        end
        if (minc_r != '0 && minp == ws_r) begin
          minh_nxt = ring(minh_r, CW'(1));
          minc_nxt = minc_r - CW'(1);
        end
        ws_nxt    = ws_r + 16'd1;
        state_nxt = lrr_pkg::ST_TAIL_RD;
      end
      lrr_pkg::ST_TAIL_RD: state_nxt = lrr_pkg::ST_TAIL;
      lrr_pkg::ST_TAIL: begin
        // a deque that stopped popping rereads the same tail and stays put
        if (max_pop) maxc_nxt = maxc_r - CW'(1);
        if (min_pop) minc_nxt = minc_r - CW'(1);
        state_nxt = (max_pop || min_pop) ? lrr_pkg::ST_TAIL_RD : lrr_pkg::ST_PUSH;
      end
      lrr_pkg::ST_PUSH: begin
        maxc_nxt  = maxc_r + CW'(1);
        minc_nxt  = minc_r + CW'(1);
        state_nxt = lrr_pkg::ST_SHR_RD;
      end
      lrr_pkg::ST_SHR_RD: state_nxt = lrr_pkg::ST_SHR;
      lrr_pkg::ST_SHR: begin
        if (ws_r != pos_r && diff > $signed({2'b00, range_limit})) begin
          if (maxc_r != '0 && maxp == ws_r) begin
            maxh_nxt = ring(maxh_r, CW'(1));
            maxc_nxt = maxc_r - CW'(1);
          end
          if (minc_r != '0 && minp == ws_r) begin
            minh_nxt = ring(minh_r, CW'(1));
            minc_nxt = minc_r - CW'(1);
          end
          ws_nxt    = ws_r + 16'd1;
          state_nxt = lrr_pkg::ST_SHR_RD;
        end else begin
          state_nxt = lrr_pkg::ST_OUT;
        end
      end
      lrr_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          res_nxt.window_length  = len11;
          res_nxt.longest_length = (len11 > best_r) ? len11 : best_r;
          res_nxt.capped         = capped_r;
          res_nxt.final_result   = last_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = lrr_pkg::ST_IDLE;
          if (last_r) begin
            pos_nxt  = '0;
            ws_nxt   = '0;
            maxh_nxt = '0;
            minh_nxt = '0;
            maxc_nxt = '0;
            minc_nxt = '0;
            best_nxt = '0;
          end else begin
            pos_nxt  = pos_r + 16'd1;
            best_nxt = (len11 > best_r) ? len11 : best_r;
          end
        end
      end
      default: state_nxt = lrr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrr_pkg::ST_IDLE;
      pos_r       <= '0;
      ws_r        <= '0;
      maxh_r      <= '0;
      minh_r      <= '0;
      maxc_r      <= '0;
      minc_r      <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      ws_r        <= ws_nxt;
      maxh_r      <= maxh_nxt;
      minh_r      <= minh_nxt;
      maxc_r      <= maxc_nxt;
      minc_r      <= minc_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r      <= x_nxt;
    last_r   <= last_nxt;
    capped_r <= capped_nxt;
    res_r    <= res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.longest_length = res_r.longest_length;
  assign out_ch.window_length  = res_r.window_length;
  assign out_ch.capped         = res_r.capped;
  assign out_ch.final_result   = res_r.final_result;

endmodule

// File: tb/longest_run_within_range_top_tb.sv
module longest_run_within_range_top_tb;

  localparam int SampleW    = lrr_pkg::SampleW;
  localparam int LenW       = lrr_pkg::LenW;
  localparam int LimitW     = lrr_pkg::LimitW;
  localparam int PosW       = lrr_pkg::PosW;
  localparam int WindowMax  = 1024;
  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 40;
  localparam int ItemsMax   = 4096;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LimitW-1:0] cfg_wdata;

  lrr_in_if  in_ch ();
  lrr_out_if out_ch ();

  longest_run_within_range_top #(.WINDOW_MAX(WindowMax)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // predictor state, deques kept as rings with head and count
  logic [LimitW-1:0]         range_limit;
  logic signed [SampleW-1:0] max_val [WindowMax];
  logic [PosW-1:0]           max_pos [WindowMax];
  logic signed [SampleW-1:0] min_val [WindowMax];
  logic [PosW-1:0]           min_pos [WindowMax];
  int                        max_head = 0;
  int                        max_cnt = 0;
  int                        min_head = 0;
  int                        min_cnt = 0;
  logic [PosW-1:0]           window_start = '0;
  logic [PosW-1:0]           next_pos = '0;
  int unsigned               best_len = 0;

  lrr_pkg::item_t   pending [ItemsMax];
  int               pend_wr = 0;
  int               pend_rd = 0;
  lrr_pkg::result_t expected [ItemsMax];
  int               exp_wr = 0;
  int               exp_rd = 0;
  int               error_count = 0;
  int               cycle_count = 0;

  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [LenW-1:0] sat_len(int unsigned v);
    return (v > 2047) ? 11'd2047 : LenW'(v);
  endfunction

  function automatic int ring_at(int h, int off);
    return (h + off) % WindowMax;
  endfunction

  function automatic void clear_window();
    max_head = 0;
    max_cnt = 0;
    min_head = 0;
    min_cnt = 0;
    window_start = '0;
    next_pos = '0;
    best_len = 0;
  endfunction

  function automatic void advance_start();
    if (max_cnt > 0 && max_pos[max_head] == window_start) begin
      max_head = ring_at(max_head, 1);
      max_cnt--;
    end
    if (min_cnt > 0 && min_pos[min_head] == window_start) begin
      min_head = ring_at(min_head, 1);
      min_cnt--;
    end
    window_start = window_start + 1'b1;
  endfunction

  function automatic lrr_pkg::result_t predict_window(lrr_pkg::item_t it);
    lrr_pkg::result_t r;
    logic [PosW-1:0]  pos;
    logic [PosW-1:0]  span;
    int unsigned      len;
    int               t;
    pos = next_pos;
    r.capped = 1'b0;
    span = pos - window_start;
    if (span >= PosW'(WindowMax)) begin
      advance_start();
      r.capped = 1'b1;
    end
    while (max_cnt > 0 && max_val[ring_at(max_head, max_cnt - 1)] < it.sample) max_cnt--;
    t = ring_at(max_head, max_cnt);
    max_val[t] = it.sample;
    max_pos[t] = pos;
    max_cnt++;
    while (min_cnt > 0 && min_val[ring_at(min_head, min_cnt - 1)] > it.sample) min_cnt--;
    t = ring_at(min_head, min_cnt);
    min_val[t] = it.sample;
    min_pos[t] = pos;
    min_cnt++;
    while (window_start != pos &&
           (longint'(max_val[max_head]) - longint'(min_val[min_head]) >
            longint'({1'b0, range_limit})))
      advance_start();
    span = pos - window_start;
    len = int'(span) + 1;
    if (len > best_len) best_len = len;
    next_pos = pos + 1'b1;
    r.longest_length = sat_len(best_len);
    r.window_length = sat_len(len);
    r.final_result = it.last_sample;
    if (it.last_sample) clear_window();
    return r;
  endfunction

  // sender: bursts of random length, random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      in_ch.last_sample <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
      pend_rd <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pend_rd < pend_wr) begin
        in_ch.valid <= 1'b1;
        in_ch.sample <= pending[pend_rd].sample;
        in_ch.last_sample <= pending[pend_rd].last_sample;
        pend_rd <= pend_rd + 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: always ready, random, or long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    lrr_pkg::result_t got;
    lrr_pkg::result_t want;
    lrr_pkg::item_t   it;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.sample = in_ch.sample;
        it.last_sample = in_ch.last_sample;
        expected[exp_wr] = predict_window(it);
        exp_wr = exp_wr + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.longest_length = out_ch.longest_length;
        got.window_length = out_ch.window_length;
        got.capped = out_ch.capped;
        got.final_result = out_ch.final_result;
        if (exp_rd == exp_wr) begin
          $error("unexpected result transfer");
          error_count++;
        end else begin
          want = expected[exp_rd];
          exp_rd = exp_rd + 1;
          if (got.longest_length !== want.longest_length) begin
            $error("longest_length: expected %0d, got %0d", want.longest_length,
                   got.longest_length);
            error_count++;
          end
          if (got.window_length !== want.window_length) begin
            $error("window_length: expected %0d, got %0d", want.window_length,
                   got.window_length);
            error_count++;
          end
          if (got.capped !== want.capped) begin
            $error("capped: expected %0b, got %0b", want.capped, got.capped);
            error_count++;
          end
          if (got.final_result !== want.final_result) begin
            $error("final_result: expected %0b, got %0b", want.final_result,
                   got.final_result);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("longest_run_within_range_top_tb: done, errors");
      $finish;
    end
  end

  task automatic add_sample(logic signed [SampleW-1:0] s, logic last);
    lrr_pkg::item_t it;
    it.sample = s;
    it.last_sample = last;
    pending[pend_wr] = it;
    pend_wr = pend_wr + 1;
  endtask

  // block goes quiet: everything sent, every result back, then a settle pause
  task automatic drain();
    while (pend_rd < pend_wr || in_ch.valid || exp_rd != exp_wr)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    range_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SampleW-1:0] bounded_sample(int unsigned b);
    return SampleW'(longint'($urandom_range(0, 2 * b)) - longint'(b));
  endfunction

  // short sequences; kind 0 small values, 1 full range, 2 mid range
  task automatic random_sequences(int count, int kind);
    int n;
    int k;
    logic signed [SampleW-1:0] s;
    n = 0;
    while (n < count) begin
      k = $urandom_range(1, 40);
      for (int i = 0; i < k && n < count; i++) begin
        case (kind)
          0: s = bounded_sample(20);
          1: s = $urandom;
          default: s = bounded_sample(32'h3fff_ffff);
        endcase
        add_sample(s, (i == k - 1) || (n == count - 1));
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    range_limit = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // zero limit: equal values are kept, any change restarts the window
    write_limit('0);
    add_sample(5, 0); add_sample(5, 0); add_sample(5, 0);
    add_sample(-3, 0); add_sample(-3, 1);
    add_sample(32'sh7fff_ffff, 0); add_sample(32'sh8000_0000, 0); add_sample(0, 1);
    drain();

    // widest limit still rejects a full-scale swing
    write_limit({LimitW{1'b1}});
    add_sample(32'sh8000_0000, 0); add_sample(32'sh7fff_ffff, 0);
    add_sample(32'sh8000_0000, 0); add_sample(0, 0); add_sample(-1, 1);
    add_sample(7, 0); add_sample(7, 0); add_sample(-7, 1);
    drain();

    write_limit(31'd10);
    add_sample(0, 0); add_sample(10, 0); add_sample(-1, 0);
    add_sample(4, 0); add_sample(15, 1);
    drain();

    // long sequence past the window cap
    write_limit({LimitW{1'b1}});
    for (int i = 0; i < WindowMax + 80; i++)
      add_sample(bounded_sample(32'h3fff_ffff), i == WindowMax + 79);
    drain();

    write_limit(31'($urandom_range(0, 15)));
    random_sequences(70, 0);
    drain();

    write_limit(31'($urandom));
    random_sequences(60, 1);
    drain();

    write_limit({LimitW{1'b1}});
    random_sequences(60, 2);
    drain();

    write_limit('0);
    random_sequences(50, 0);
    drain();

    if (error_count == 0 && exp_rd == exp_wr)
      $display("longest_run_within_range_top_tb: done, clean");
    else
      $display("longest_run_within_range_top_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
src/lrr_pkg.sv
src/lrr_if.sv
src/lrr_front.sv
src/lrr_back.sv
src/longest_run_within_range_top.sv
tb/longest_run_within_range_top_tb.sv
